// ===== rtl/core/msort_pkg.sv =====
`default_nettype none

package msort_pkg;

   // Number of elements one set may hold.
   localparam int DEPTH = 64;

   // Element width, address width into the buffers, and element count width.
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Width for run bound sums before they are clipped to the set size.
   localparam int SUM_W  = CNT_W + 2;

endpackage

`default_nettype wire

// ===== rtl/core/msort_ram.sv =====
`default_nettype none

module msort_ram #(
   parameter int DATA_W    = 32,
   parameter int NUM_WORDS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(NUM_WORDS)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]            wr_data,
   input  wire logic [$clog2(NUM_WORDS)-1:0] rd_addr_a,
   output logic      [DATA_W-1:0]            rd_data_a,
   input  wire logic [$clog2(NUM_WORDS)-1:0] rd_addr_b,
   output logic      [DATA_W-1:0]            rd_data_b
);

   logic [DATA_W-1:0] mem_ff [NUM_WORDS];

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== rtl/core/merge_sort_engine.sv =====
// Channel   Direction  Signals                                                     Width
// req       in         req_valid/req_ready, req_value, req_last_in                 32 + 1
// rsp       out        rsp_valid/rsp_ready, rsp_sorted_value, rsp_last_out, rsp_overflow  32 + 1 + 1
//
// Loading takes one request per cycle; the request with req_last_in set starts the sort.
// A set of n elements then takes ceil(log2 n) merge passes, with a setup step per run
// pair and a fetch and a compare step per element over the shared buffer read ports,
// and is then emitted. req_ready is low from the sort start until the last result is
// registered. A stalled result holds the emit loop; reset is synchronous and needs no
// clearing pass.
`default_nettype none

module merge_sort_engine
   import msort_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     req_last_in,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_last_out,
   output logic                          rsp_overflow
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RUN,
      ST_FETCH,
      ST_MERGE,
      ST_OUT_READ,
      ST_OUT_LOAD
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    overflow_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [CNT_W-1:0]        width_ff;
   logic [CNT_W-1:0]        lo_ff;
   logic [CNT_W-1:0]        mid_ff;
   logic [CNT_W-1:0]        hi_ff;
   logic [CNT_W-1:0]        i_ff;
   logic [CNT_W-1:0]        j_ff;
   logic [CNT_W-1:0]        k_ff;
   logic                    src_ff;
   logic                    rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                    rsp_last_ff;
   logic                    rsp_overflow_ff;

   logic                    req_fire;
   logic                    has_room;
   logic                    load_we;
   logic                    merge_we;
   logic [CNT_W-1:0]        count_plus;
   logic [SUM_W-1:0]        mid_sum;
   logic [SUM_W-1:0]        hi_sum;
   logic [SUM_W-1:0]        n_ext;
   logic [CNT_W-1:0]        run_mid;
   logic [CNT_W-1:0]        run_hi;
   logic [CNT_W:0]          width_dbl;
   logic [CNT_W-1:0]        k_next;
   logic                    take_left;
   logic                    rsp_slot_free;

   logic [ADDR_W-1:0]       wr_addr;
   logic [DATA_W-1:0]       wr_data;
   logic [ADDR_W-1:0]       rd_addr_a;
   logic [ADDR_W-1:0]       rd_addr_b;
   logic [DATA_W-1:0]       b0_rd_a;
   logic [DATA_W-1:0]       b0_rd_b;
   logic [DATA_W-1:0]       b1_rd_a;
   logic [DATA_W-1:0]       b1_rd_b;
   logic signed [DATA_W-1:0] head_a;
   logic signed [DATA_W-1:0] head_b;

   // Request side: the buffer takes a new element while there is room.
   assign req_ready  = (state_ff == ST_LOAD);
   assign req_fire   = req_valid && req_ready;
   assign has_room   = (count_ff < CNT_W'(DEPTH));
   assign load_we    = req_fire && has_room;
   assign count_plus = has_room ? count_ff + CNT_W'(1) : count_ff;

   // Bounds of the next pair of runs, clipped to the set size.
   assign n_ext     = SUM_W'(n_ff);
   assign mid_sum   = SUM_W'(lo_ff) + SUM_W'(width_ff);
   assign hi_sum    = mid_sum + SUM_W'(width_ff);
   assign run_mid   = (mid_sum > n_ext) ? n_ff : mid_sum[CNT_W-1:0];
   assign run_hi    = (hi_sum > n_ext) ? n_ff : hi_sum[CNT_W-1:0];
   assign width_dbl = {width_ff, 1'b0};

   // Heads of both runs come from the current source bank.
   assign head_a = src_ff ? b1_rd_a : b0_rd_a;
   assign head_b = src_ff ? b1_rd_b : b0_rd_b;

   // Compare unit: the left run wins ties, which keeps the sort stable.
   assign take_left = (i_ff < mid_ff) && ((j_ff >= hi_ff) || (head_a <= head_b));
   assign k_next    = k_ff + CNT_W'(1);
   assign merge_we  = (state_ff == ST_MERGE);

   // Buffer addressing: loads go to bank 0, merges to the bank that is not the source.
   assign wr_addr   = (state_ff == ST_LOAD) ? count_ff[ADDR_W-1:0] : k_ff[ADDR_W-1:0];
   assign wr_data   = (state_ff == ST_LOAD) ? req_value : (take_left ? head_a : head_b);
   assign rd_addr_a = (state_ff == ST_OUT_READ || state_ff == ST_OUT_LOAD) ?
                      k_ff[ADDR_W-1:0] : i_ff[ADDR_W-1:0];
   assign rd_addr_b = j_ff[ADDR_W-1:0];

   msort_ram #(
      .DATA_W    (DATA_W),
      .NUM_WORDS (DEPTH)
   ) u_bank0 (
      .clock     (clock),
      .wr_en     (load_we || (merge_we && src_ff)),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (b0_rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (b0_rd_b)
   );

   msort_ram #(
      .DATA_W    (DATA_W),
      .NUM_WORDS (DEPTH)
   ) u_bank1 (
      .clock     (clock),
      .wr_en     (merge_we && !src_ff),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (b1_rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (b1_rd_b)
   );

   // The result register is free when empty or when its value is taken now.
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The emit state refills the result register itself when it is taken.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT_LOAD) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  count_ff <= count_plus;
                  if (!has_room) begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_last_in) begin
                     n_ff     <= count_plus;
                     width_ff <= CNT_W'(1);
                     lo_ff    <= '0;
                     k_ff     <= '0;
                     src_ff   <= 1'b0;
                     if (count_plus == CNT_W'(1)) begin
                        state_ff <= ST_OUT_READ;
                     end else begin
                        state_ff <= ST_RUN;
                     end
                  end
               end
            end
            ST_RUN: begin
               mid_ff   <= run_mid;
               hi_ff    <= run_hi;
               i_ff     <= lo_ff;
               j_ff     <= run_mid;
               k_ff     <= lo_ff;
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               state_ff <= ST_MERGE;
            end
            ST_MERGE: begin
               if (take_left) begin
                  i_ff <= i_ff + CNT_W'(1);
               end else begin
                  j_ff <= j_ff + CNT_W'(1);
               end
               if (k_next == hi_ff) begin
                  if (hi_ff == n_ff) begin
                     // Pass complete: the destination bank becomes the source.
                     src_ff <= !src_ff;
                     lo_ff  <= '0;
                     if (width_dbl < (CNT_W + 1)'(n_ff)) begin
                        width_ff <= width_dbl[CNT_W-1:0];
                        k_ff     <= k_next;
                        state_ff <= ST_RUN;
                     end else begin
                        k_ff     <= '0;
                        state_ff <= ST_OUT_READ;
                     end
                  end else begin
                     k_ff     <= k_next;
                     lo_ff    <= hi_ff;
                     state_ff <= ST_RUN;
                  end
               end else begin
                  k_ff     <= k_next;
                  state_ff <= ST_FETCH;
               end
            end
            ST_OUT_READ: begin
               state_ff <= ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
               if (rsp_slot_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_value_ff    <= head_a;
                  rsp_last_ff     <= (k_next == n_ff);
                  rsp_overflow_ff <= overflow_ff;
                  k_ff            <= k_next;
                  if (k_next == n_ff) begin
                     count_ff    <= '0;
                     overflow_ff <= 1'b0;
                     state_ff    <= ST_LOAD;
                  end else begin
                     state_ff <= ST_OUT_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   // The element count never passes the buffer depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count exceeds buffer depth");

   // During a merge the write pointer stays inside the run pair and the set.
   a_merge_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (k_ff < hi_ff) && (hi_ff <= n_ff))
      else $error("merge write pointer outside its run pair");

   // Both read pointers together account for every element written so far in the current run pair.
   a_pointer_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_MERGE) |->
      ((SUM_W'(i_ff) + SUM_W'(j_ff)) == (SUM_W'(k_ff) + SUM_W'(mid_ff))))
      else $error("merge pointers out of step");

endmodule

`default_nettype wire
